// ===== hw/rtl/tcce_pkg.sv =====
// tcce_pkg: shared types and constants for the text console cursor engine.
// Holds command codes, the classified item struct and the back-end state enum.
// No dependencies.
`default_nettype none

package tcce_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_BKSP  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [7:0] NEWLINE_CODE       = 8'd10;
  localparam logic [7:0] BLANK_CODE         = 8'd32;
  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BKSP,
    OP_CLEAR,
    OP_READ,
    OP_READ_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [7:0] char_attribute;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_BLANK,
    ST_CLEAR,
    ST_READ_WAIT
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcce_front.sv =====
// tcce_front: decodes an incoming command into a classified item.
// Depends on tcce_pkg.
`default_nettype none

module tcce_front #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  wire logic [1:0]     cmd,
  input  wire logic [7:0]     char_code,
  input  wire logic [7:0]     char_attribute,
  input  wire logic [4:0]     read_row,
  input  wire logic [6:0]     read_column,
  output tcce_pkg::item_t     item
);

  logic in_range;

  assign in_range = (32'(read_row) < ROWS) && (32'(read_column) < COLUMNS);

  always_comb begin
    item.char_code      = char_code;
    item.char_attribute = char_attribute;
    item.read_row       = read_row;
    item.read_column    = read_column;
    case (cmd)
      tcce_pkg::CMD_PUT: begin
        item.op = (char_code == tcce_pkg::NEWLINE_CODE) ? tcce_pkg::OP_NEWLINE
                                                         : tcce_pkg::OP_PUT;
      end
      tcce_pkg::CMD_BKSP:  item.op = tcce_pkg::OP_BKSP;
      tcce_pkg::CMD_CLEAR: item.op = tcce_pkg::OP_CLEAR;
      tcce_pkg::CMD_READ: begin
        // reads outside the store answer zeros without touching memory
        item.op = in_range ? tcce_pkg::OP_READ : tcce_pkg::OP_READ_OUT;
      end
      default: item.op = tcce_pkg::OP_READ_OUT;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcce_queue.sv =====
// tcce_queue: two-entry item queue between front and back.
// Depends on tcce_pkg.
`default_nettype none

module tcce_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tcce_pkg::item_t push_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output tcce_pkg::item_t      head_item
);

  tcce_pkg::item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head_item = entry_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcce_back.sv =====
// tcce_back: executes queued items against the cell store and the cursor.
// Holds the screen memory, scroll/clear sequencer and result registers. Uses tcce_pkg.
`default_nettype none

module tcce_back #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [7:0]      default_attribute,
  input  wire logic            q_valid,
  input  wire tcce_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic [4:0]           out_cursor_row_now,
  output logic [6:0]           out_cursor_column_now,
  output logic                 out_did_scroll,
  output logic [7:0]           out_cell_char,
  output logic [7:0]           out_cell_attribute
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam logic [AW-1:0] SCROLL_LAST = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] CELL_LAST   = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);

  tcce_pkg::state_t state_r, state_nxt;

  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [AW-1:0] addr_r, addr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [4:0]    out_row_r, out_row_nxt;
  logic [6:0]    out_col_r, out_col_nxt;
  logic          out_scroll_r, out_scroll_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic [7:0]    out_attr_r, out_attr_nxt;

  logic [15:0]   cell_mem_r [CELLS];
  logic [15:0]   rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic          at_last_row, at_last_col;
  logic [AW-1:0] cur_addr, item_addr;
  logic [15:0]   blank_cell;
  logic          emit;

  assign at_last_row = (cur_row_r == LAST_ROW);
  assign at_last_col = (cur_col_r == LAST_COL);
  assign cur_addr    = AW'(32'(cur_row_r) * COLUMNS + 32'(cur_col_r));
  assign item_addr   = AW'(32'(q_item.read_row) * COLUMNS + 32'(q_item.read_column));
  assign blank_cell  = {default_attribute, tcce_pkg::BLANK_CODE};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcce_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            tcce_pkg::OP_PUT: begin
              if (at_last_col && at_last_row) state_nxt = tcce_pkg::ST_SCR_RD;
            end
            tcce_pkg::OP_NEWLINE: begin
              if (at_last_row) state_nxt = tcce_pkg::ST_SCR_RD;
            end
            tcce_pkg::OP_CLEAR: state_nxt = tcce_pkg::ST_CLEAR;
            tcce_pkg::OP_READ:  state_nxt = tcce_pkg::ST_READ_WAIT;
            default:            state_nxt = tcce_pkg::ST_IDLE;
          endcase
        end
      end
      tcce_pkg::ST_SCR_RD: state_nxt = tcce_pkg::ST_SCR_WR;
      tcce_pkg::ST_SCR_WR: begin
        state_nxt = (addr_r == SCROLL_LAST) ? tcce_pkg::ST_BLANK : tcce_pkg::ST_SCR_RD;
      end
      tcce_pkg::ST_BLANK: begin
        if (addr_r == CELL_LAST) state_nxt = tcce_pkg::ST_IDLE;
      end
      tcce_pkg::ST_CLEAR: begin
        if (addr_r == CELL_LAST) state_nxt = tcce_pkg::ST_IDLE;
      end
      tcce_pkg::ST_READ_WAIT: state_nxt = tcce_pkg::ST_IDLE;
      default: state_nxt = tcce_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop          = 1'b0;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    addr_nxt       = addr_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_addr;
    mem_wdata      = blank_cell;
    mem_raddr      = item_addr;
    emit           = 1'b0;
    out_scroll_nxt = 1'b0;
    out_char_nxt   = 8'd0;
    out_attr_nxt   = 8'd0;
    case (state_r)
      tcce_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op)
            tcce_pkg::OP_PUT: begin
              mem_we    = 1'b1;
              mem_wdata = {q_item.char_attribute, q_item.char_code};
              if (at_last_col) begin
                cur_col_nxt = '0;
                if (at_last_row) begin
                  addr_nxt = '0;
                end else begin
                  cur_row_nxt = cur_row_r + RW'(1);
                  emit        = 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + CW'(1);
                emit        = 1'b1;
              end
            end
            tcce_pkg::OP_NEWLINE: begin
              cur_col_nxt = '0;
              if (at_last_row) begin
                addr_nxt = '0;
              end else begin
                cur_row_nxt = cur_row_r + RW'(1);
                emit        = 1'b1;
              end
            end
            tcce_pkg::OP_BKSP: begin
              // the cell before the cursor is cur_addr-1 on either path
              mem_waddr = cur_addr - AW'(1);
              if (cur_col_r != '0) begin
                cur_col_nxt = cur_col_r - CW'(1);
                mem_we      = 1'b1;
              end else if (cur_row_r != '0) begin
                cur_row_nxt = cur_row_r - RW'(1);
                cur_col_nxt = LAST_COL;
                mem_we      = 1'b1;
              end
              emit = 1'b1;
            end
            tcce_pkg::OP_CLEAR: begin
              cur_row_nxt = '0;
              cur_col_nxt = '0;
              addr_nxt    = '0;
            end
            tcce_pkg::OP_READ: begin
              mem_raddr = item_addr;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      tcce_pkg::ST_SCR_RD: begin
        mem_raddr = addr_r + ROW_STRIDE;
      end
      tcce_pkg::ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = rdata_r;
        addr_nxt  = addr_r + AW'(1);
      end
      tcce_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        addr_nxt  = addr_r + AW'(1);
        if (addr_r == CELL_LAST) begin
          emit           = 1'b1;
          out_scroll_nxt = 1'b1;
        end
      end
      tcce_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        addr_nxt  = addr_r + AW'(1);
        emit      = (addr_r == CELL_LAST);
      end
      tcce_pkg::ST_READ_WAIT: begin
        emit         = 1'b1;
        out_char_nxt = rdata_r[7:0];
        out_attr_nxt = rdata_r[15:8];
      end
      default: ;
    endcase
    out_valid_nxt = emit;
    out_row_nxt   = 5'(32'(cur_row_nxt));
    out_col_nxt   = 7'(32'(cur_col_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcce_pkg::ST_IDLE;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_scroll_r <= out_scroll_nxt;
    out_char_r   <= out_char_nxt;
    out_attr_r   <= out_attr_nxt;
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem_r[mem_waddr] <= mem_wdata;
    end
    rdata_r <= cell_mem_r[mem_raddr];
  end

  assign out_valid             = out_valid_r;
  assign out_cursor_row_now    = out_row_r;
  assign out_cursor_column_now = out_col_r;
  assign out_did_scroll        = out_scroll_r;
  assign out_cell_char         = out_char_r;
  assign out_cell_attribute    = out_attr_r;

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_cursor_engine.sv =====
// text_console_cursor_engine: top level of the text console cursor engine.
// Instantiates tcce_front, tcce_queue and tcce_back; uses tcce_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   input    | start / busy           | in_cmd, in_char_code, in_char_attribute,
//            |                        | in_read_row, in_read_column
//   result   | out_valid (1 cycle)    | out_cursor_row_now, out_cursor_column_now,
//            |                        | out_did_scroll, out_cell_char, out_cell_attribute
//   config   | cfg_we                 | cfg_wdata (default attribute)
//
// Put, newline, backspace and out-of-range read: the item passes the queue register, then
// the result register. Read cell adds a registered memory read. Clear writes all ROWS*COLUMNS cells.
// Scroll copies (ROWS-1)*COLUMNS cells up, each by a read and a write state, then blanks the last row.
// A two-item queue lets items be taken while the back end works; busy is high when full.
// Synchronous active-low reset homes the cursor and empties the queue; memory is not cleared.
// Results cannot be stalled by the receiver.
`default_nettype none

module text_console_cursor_engine #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_char_code,
  input  wire logic [7:0] in_char_attribute,
  input  wire logic [4:0] in_read_row,
  input  wire logic [6:0] in_read_column,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  output logic            out_valid,
  output logic [4:0]      out_cursor_row_now,
  output logic [6:0]      out_cursor_column_now,
  output logic            out_did_scroll,
  output logic [7:0]      out_cell_char,
  output logic [7:0]      out_cell_attribute
);

  tcce_pkg::item_t in_item;
  tcce_pkg::item_t head_item;
  logic            q_full, q_not_empty, q_pop, push;
  logic [7:0]      default_attr_r;

  assign busy = q_full;
  assign push = start && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= tcce_pkg::DEFAULT_ATTR_RESET;
    end else if (cfg_we) begin
      default_attr_r <= cfg_wdata;
    end
  end

  tcce_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .cmd            (in_cmd),
    .char_code      (in_char_code),
    .char_attribute (in_char_attribute),
    .read_row       (in_read_row),
    .read_column    (in_read_column),
    .item           (in_item)
  );

  tcce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (in_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  tcce_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .default_attribute     (default_attr_r),
    .q_valid               (q_not_empty),
    .q_item                (head_item),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_cursor_row_now    (out_cursor_row_now),
    .out_cursor_column_now (out_cursor_column_now),
    .out_did_scroll        (out_did_scroll),
    .out_cell_char         (out_cell_char),
    .out_cell_attribute    (out_cell_attribute)
  );

  // a scroll always leaves the cursor at the start of the last row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_did_scroll) |->
      (out_cursor_column_now == 7'd0) && (out_cursor_row_now == 5'(ROWS - 1)))
    else $error("scroll result with cursor off the last row start");

  // scroll results never carry cell data
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_did_scroll) |->
      (out_cell_char == 8'd0) && (out_cell_attribute == 8'd0))
    else $error("scroll result carries cell data");

  // no result can appear without an item having been taken from the queue
  a_result_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(q_pop)) |-> $past(u_back.state_r != tcce_pkg::ST_IDLE))
    else $error("result without a dequeued item");

endmodule

`default_nettype wire
